@@ rtl/sps_pkg.sv @@
// Shared constants, types and a helper function for the scan-out block.
package sps_pkg;

   // Raster geometry.
   localparam int VERT_OFFSET     = 20;
   localparam int HORZ_OFFSET     = 48;
   localparam int LINES_PER_FRAME = 262;
   localparam int SCREEN_WIDTH    = 320;
   localparam int MEM_DEPTH       = 4096;
   localparam int SLOTS_PER_LINE  = 456 / 4;
   localparam int WINDOW_BYTES    = 80;
   localparam int HORZ_SLOTS      = HORZ_OFFSET / 4;

   // Field widths.
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int LINE_W    = 9;
   localparam int SLOT_W    = 7;
   localparam int COLUMN_W  = 10;
   localparam int PIXEL_W   = 9;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // Item modes.
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_LINE  = 2'd1;
   localparam logic [1:0] MODE_SLOT  = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_RES     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_SPLIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK_LINE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_COLORS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_COLORS  = 3'd5;

   // Per-slot decisions handed from the sequencer to the pixel stage.
   typedef struct packed {
      logic valid;
      logic fetch;
      logic use_left;
      logic doubled;
      logic line_end;
   } slot_ctrl_type;

   // Color code of one 2-bit pixel: the selected color register shifted left one.
   function automatic logic [PIXEL_W-1:0] color_code(input logic [31:0] set,
                                                     input logic [1:0]  pix);
      logic [7:0] reg_val;
      case (pix)
         2'd0:    reg_val = set[7:0];
         2'd1:    reg_val = set[15:8];
         2'd2:    reg_val = set[23:16];
         default: reg_val = set[31:24];
      endcase
      return {reg_val, 1'b0};
   endfunction

endpackage

@@ rtl/sps_if.sv @@
// Channel interfaces for items, results and register writes.
interface sps_req_if import sps_pkg::*;;
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic [LINE_W-1:0] line_number;
   logic [ADDR_W-1:0] mem_address;
   logic [7:0]        mem_data;
   modport source(output valid, mode, line_number, mem_address, mem_data, input ready);
   modport sink(input valid, mode, line_number, mem_address, mem_data, output ready);
endinterface

interface sps_rsp_if import sps_pkg::*;;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_a;
   logic [PIXEL_W-1:0] pixel_b;
   logic [PIXEL_W-1:0] pixel_c;
   logic [PIXEL_W-1:0] pixel_d;
   logic               doubled;
   logic               line_end;
   modport source(output valid, pixel_a, pixel_b, pixel_c, pixel_d, doubled, line_end,
                  input ready);
   modport sink(input valid, pixel_a, pixel_b, pixel_c, pixel_d, doubled, line_end,
                output ready);
endinterface

interface sps_csr_if import sps_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/sps_vram.sv @@
// Screen memory with one write port, one registered read port and a clearing pass.
module sps_vram import sps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data,
   output logic              clear_done
);

   logic [7:0]        mem [MEM_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;
   logic              clr_done_ff;
   logic              clr_done_in;

   // Clearing sweep after reset, one byte per cycle.
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_done_in = clr_done_ff;
      if (!clr_done_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
            clr_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_done_ff <= 1'b0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_done_ff <= clr_done_in;
      end
   end

   // Memory array: sweep writes zero, otherwise item writes.
   always_ff @(posedge clock) begin
      if (!clr_done_ff) begin
         mem[clr_addr_ff] <= 8'd0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, held until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_done = clr_done_ff;

endmodule

@@ rtl/sps_seq.sv @@
// Line and slot sequencer: raster position, fetch address and per-slot decisions.
module sps_seq import sps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        mode,
   input  logic [LINE_W-1:0] line_number,
   input  logic              high_res,
   input  logic [7:0]        color_split,
   input  logic [7:0]        blank_line,
   output logic [ADDR_W-1:0] fetch_addr,
   output slot_ctrl_type     slot_ctrl
);

   logic [SLOT_W-1:0]   slot_ff,   slot_in;
   logic [COLUMN_W-1:0] column_ff, column_in;
   logic [ADDR_W-1:0]   fetch_ff,  fetch_in;
   logic [LINE_W-1:0]   line_ff,   line_in;
   logic                open_ff,   open_in;

   logic signed [10:0]  eff_line;
   logic [10:0]         eff_wrap;
   logic [LINE_W-1:0]   new_line;
   logic [15:0]         off_hi;
   logic [15:0]         off_lo;
   logic signed [8:0]   win_col;
   logic                in_window;
   logic                do_fetch;
   logic [SLOT_W-1:0]   slot_next;
   logic [COLUMN_W:0]   column_sum;
   logic [COLUMN_W-1:0] column_next;
   logic                end_of_line;
   logic                slot_go;

   // Display line and memory offset for a line start.
   always_comb begin
      eff_line = $signed({2'b00, line_number}) - 11'(VERT_OFFSET);
      eff_wrap = (eff_line < 0) ? 11'(eff_line + 11'(LINES_PER_FRAME)) : 11'(eff_line);
      new_line = eff_wrap[LINE_W-1:0];
      off_hi   = {7'd0, new_line} * 16'd80;
      off_lo   = {8'd0, new_line[LINE_W-1:1]} * 16'd40;
   end

   // Slot decisions: window, color set, fetch and end of line.
   always_comb begin
      win_col     = $signed({2'b00, slot_ff}) - 9'(HORZ_SLOTS);
      in_window   = (win_col >= 0) && (win_col < 9'sd80);
      do_fetch    = in_window && (line_ff < {1'b0, blank_line});
      slot_next   = high_res ? slot_ff + 1'b1 : slot_ff + 2'd2;
      column_sum  = {1'b0, column_ff} + (high_res ? 11'd4 : 11'd8);
      column_next = (column_sum > 11'(SCREEN_WIDTH)) ? COLUMN_W'(SCREEN_WIDTH)
                                                     : column_sum[COLUMN_W-1:0];
      end_of_line = ({1'b0, slot_next} >= 8'(SLOTS_PER_LINE)) ||
                    (column_next >= COLUMN_W'(SCREEN_WIDTH));
      slot_go     = accept && (mode == MODE_SLOT) && open_ff;

      slot_ctrl.valid    = slot_go;
      slot_ctrl.fetch    = do_fetch;
      slot_ctrl.use_left = win_col < $signed({1'b0, color_split});
      slot_ctrl.doubled  = !high_res;
      slot_ctrl.line_end = end_of_line;
   end

   // Next state.
   always_comb begin
      slot_in   = slot_ff;
      column_in = column_ff;
      fetch_in  = fetch_ff;
      line_in   = line_ff;
      open_in   = open_ff;
      if (accept && (mode == MODE_LINE)) begin
         line_in   = new_line;
         fetch_in  = high_res ? off_hi[ADDR_W-1:0] : off_lo[ADDR_W-1:0];
         slot_in   = '0;
         column_in = '0;
         open_in   = 1'b1;
      end else if (slot_go) begin
         slot_in   = slot_next;
         column_in = column_next;
         if (do_fetch) begin
            fetch_in = fetch_ff + 1'b1;
         end
         if (end_of_line) begin
            open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= '0;
         column_ff <= '0;
         fetch_ff  <= '0;
         line_ff   <= '0;
         open_ff   <= 1'b0;
      end else begin
         slot_ff   <= slot_in;
         column_ff <= column_in;
         fetch_ff  <= fetch_in;
         line_ff   <= line_in;
         open_ff   <= open_in;
      end
   end

   assign fetch_addr = fetch_ff;

endmodule

@@ rtl/sps_pixel.sv @@
// Pixel stage: holds slot decisions during the read, then builds the result word.
module sps_pixel import sps_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  slot_ctrl_type   slot_ctrl,
   input  logic [7:0]      rd_data,
   input  logic [7:0]      background_byte,
   input  logic [31:0]     right_colors,
   input  logic [31:0]     left_colors,
   output logic            can_accept,
   sps_rsp_if.source       rsp
);

   slot_ctrl_type      s1_ff, s1_in;
   logic               out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0] pix_a_ff, pix_b_ff, pix_c_ff, pix_d_ff;
   logic               doubled_ff, line_end_ff;
   logic               out_free;
   logic               advance;
   logic [7:0]         byte_val;
   logic [31:0]        set;

   // Handshake between the read stage and the output register.
   always_comb begin
      out_free     = !out_valid_ff || rsp.ready;
      advance      = s1_ff.valid && out_free;
      can_accept   = !s1_ff.valid || out_free;
      s1_in        = s1_ff;
      out_valid_in = out_valid_ff;
      if (accept) begin
         s1_in = slot_ctrl;
      end else if (advance) begin
         s1_in.valid = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Pixel byte and color set for the slot in the read stage.
   always_comb begin
      byte_val = s1_ff.fetch ? rd_data : background_byte;
      set      = s1_ff.use_left ? left_colors : right_colors;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_ff        <= s1_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (advance) begin
         pix_a_ff    <= color_code(set, byte_val[7:6]);
         pix_b_ff    <= color_code(set, byte_val[5:4]);
         pix_c_ff    <= color_code(set, byte_val[3:2]);
         pix_d_ff    <= color_code(set, byte_val[1:0]);
         doubled_ff  <= s1_ff.doubled;
         line_end_ff <= s1_ff.line_end;
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.pixel_a  = pix_a_ff;
   assign rsp.pixel_b  = pix_b_ff;
   assign rsp.pixel_c  = pix_c_ff;
   assign rsp.pixel_d  = pix_d_ff;
   assign rsp.doubled  = doubled_ff;
   assign rsp.line_end = line_end_ff;

endmodule

@@ rtl/scanline_pixel_scanout_top.sv @@
// Top level of the 2-bit-per-pixel scan-out block: registers and stage wiring.
//
//   Channel    Direction  Word
//   req_chan   in         mode, line_number, mem_address, mem_data
//   rsp_chan   out        pixel_a..pixel_d, doubled, line_end (slot words only)
//   csr_chan   in         index, data (register write, always ready)
//
// One word is taken per cycle while the clearing pass is done and the read stage can
// take it. A slot word is taken into the read stage, and the taking edge also latches
// the screen memory read; the color lookup then runs from the read stage into the
// result register. After reset a clearing pass zeroes the 4096-byte screen memory,
// one byte a cycle, and req_chan stays not ready until the pass is done.
// A stalled result holds its register; one more word waits in the read stage.
module scanline_pixel_scanout_top import sps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sps_req_if.sink    req_chan,
   sps_rsp_if.source  rsp_chan,
   sps_csr_if.sink    csr_chan
);

   logic              high_res_ff;
   logic [7:0]        color_split_ff;
   logic [7:0]        background_ff;
   logic [7:0]        blank_line_ff;
   logic [31:0]       right_colors_ff;
   logic [31:0]       left_colors_ff;
   logic              accept;
   logic              can_accept;
   logic              clear_done;
   logic [ADDR_W-1:0] fetch_addr;
   logic [7:0]        rd_data;
   slot_ctrl_type     slot_ctrl;

   // Register writes.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_res_ff     <= 1'b0;
         color_split_ff  <= '0;
         background_ff   <= '0;
         blank_line_ff   <= '0;
         right_colors_ff <= '0;
         left_colors_ff  <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_HIGH_RES:     high_res_ff     <= csr_chan.data[0];
            CSR_COLOR_SPLIT:  color_split_ff  <= csr_chan.data[7:0];
            CSR_BACKGROUND:   background_ff   <= csr_chan.data[7:0];
            CSR_BLANK_LINE:   blank_line_ff   <= csr_chan.data[7:0];
            CSR_RIGHT_COLORS: right_colors_ff <= csr_chan.data;
            CSR_LEFT_COLORS:  left_colors_ff  <= csr_chan.data;
            default:          ;
         endcase
      end
   end

   // Input handshake.
   assign req_chan.ready = clear_done && can_accept;
   assign accept         = req_chan.valid && req_chan.ready;

   sps_vram u_vram (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (accept && (req_chan.mode == MODE_WRITE)),
      .wr_addr    (req_chan.mem_address),
      .wr_data    (req_chan.mem_data),
      .rd_en      (slot_ctrl.valid && slot_ctrl.fetch),
      .rd_addr    (fetch_addr),
      .rd_data    (rd_data),
      .clear_done (clear_done)
   );

   sps_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mode        (req_chan.mode),
      .line_number (req_chan.line_number),
      .high_res    (high_res_ff),
      .color_split (color_split_ff),
      .blank_line  (blank_line_ff),
      .fetch_addr  (fetch_addr),
      .slot_ctrl   (slot_ctrl)
   );

   sps_pixel u_pixel (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .slot_ctrl       (slot_ctrl),
      .rd_data         (rd_data),
      .background_byte (background_ff),
      .right_colors    (right_colors_ff),
      .left_colors     (left_colors_ff),
      .can_accept      (can_accept),
      .rsp             (rsp_chan)
   );

endmodule

@@ tb/sv/scanline_pixel_scanout_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the scan-out block; a shadow model predicts every pixel word.
module scanline_pixel_scanout_top_tb;
   import sps_pkg::*;

   localparam logic [1:0] MODE_UNUSED   = 2'd3;
   localparam int SETTLE_CYCLES         = 4;
   localparam int HOLD_OFF_CYCLES       = 400;
   localparam int PHASE_WORDS           = 230;

   // One input word as the block takes it.
   typedef struct packed {
      logic [1:0]        mode;
      logic [LINE_W-1:0] line_number;
      logic [ADDR_W-1:0] mem_address;
      logic [7:0]        mem_data;
   } scan_word_type;

   // One result word: four color codes and the two flags.
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_a;
      logic [PIXEL_W-1:0] pixel_b;
      logic [PIXEL_W-1:0] pixel_c;
      logic [PIXEL_W-1:0] pixel_d;
      logic               doubled;
      logic               line_end;
   } pixel_group_type;

   logic clock = 1'b0;
   logic reset;

   sps_req_if req_chan();
   sps_rsp_if rsp_chan();
   sps_csr_if csr_chan();

   scanline_pixel_scanout_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the screen memory, the registers and the raster state.
   logic [7:0]        shadow_mem [MEM_DEPTH];
   bit                cfg_high_res;
   logic [7:0]        cfg_split;
   logic [7:0]        cfg_background;
   logic [7:0]        cfg_blank;
   logic [31:0]       cfg_right;
   logic [31:0]       cfg_left;
   int                slot_pos;
   int                out_col;
   int                active_line;
   logic [ADDR_W-1:0] fetch_addr;
   bit                line_open;

   scan_word_type   pending_words [$];
   pixel_group_type expected_pixels [$];

   bit failed;
   bit steady;
   bit hold_request;
   bit hold_done;
   int hold_left;

   // Applies one word to the shadow state; returns 1 with the pixel word it yields.
   function automatic bit predict_scanout(input scan_word_type w, output pixel_group_type px);
      int                 step;
      int                 eff;
      int                 col;
      int                 pix;
      logic [31:0]        colors;
      logic [7:0]         data;
      logic [PIXEL_W-1:0] codes [4];
      px = '0;
      step = cfg_high_res ? 1 : 2;
      case (w.mode)
         MODE_WRITE: begin
            shadow_mem[w.mem_address] = w.mem_data;
            return 1'b0;
         end
         MODE_LINE: begin
            eff = int'(w.line_number) - VERT_OFFSET;
            if (eff < 0) begin
               eff += LINES_PER_FRAME;
            end
            active_line = eff & 'h1ff;
            fetch_addr = ADDR_W'((active_line / step) * (WINDOW_BYTES / step));
            slot_pos = 0;
            out_col = 0;
            line_open = 1'b1;
            return 1'b0;
         end
         MODE_SLOT: begin
            if (!line_open) begin
               return 1'b0;
            end
         end
         default: begin
            return 1'b0;
         end
      endcase

      // Slot inside an open line: pick the color set, then the byte.
      col = slot_pos - HORZ_SLOTS;
      colors = (col < int'(cfg_split)) ? cfg_left : cfg_right;
      if (col >= 0 && col < WINDOW_BYTES && active_line < int'(cfg_blank)) begin
         data = shadow_mem[fetch_addr];
         fetch_addr++;
      end else begin
         data = cfg_background;
      end
      for (int i = 0; i < 4; i++) begin
         pix = (int'(data) >> (6 - 2 * i)) & 3;
         codes[i] = {colors[8 * pix +: 8], 1'b0};
      end
      px.pixel_a = codes[0];
      px.pixel_b = codes[1];
      px.pixel_c = codes[2];
      px.pixel_d = codes[3];
      px.doubled = !cfg_high_res;

      // Advance the raster; the column count saturates at the screen width.
      slot_pos += step;
      out_col += 4 * step;
      if (out_col > SCREEN_WIDTH) begin
         out_col = SCREEN_WIDTH;
      end
      px.line_end = (slot_pos >= SLOTS_PER_LINE) || (out_col >= SCREEN_WIDTH);
      if (px.line_end) begin
         line_open = 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void push_word(input logic [1:0] mode, input int line, input int addr,
                                     input int data);
      scan_word_type w;
      w.mode = mode;
      w.line_number = LINE_W'(line);
      w.mem_address = ADDR_W'(addr);
      w.mem_data = 8'(data);
      pending_words.push_back(w);
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         failed = 1'b1;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // Register write; the shadow copy follows at the handshake.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_HIGH_RES:     cfg_high_res = value[0];
         CSR_COLOR_SPLIT:  cfg_split = value[7:0];
         CSR_BACKGROUND:   cfg_background = value[7:0];
         CSR_BLANK_LINE:   cfg_blank = value[7:0];
         CSR_RIGHT_COLORS: cfg_right = value;
         CSR_LEFT_COLORS:  cfg_left = value;
         default: begin
         end
      endcase
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_registers(input bit hr, input logic [7:0] split,
                                    input logic [7:0] background, input logic [7:0] blank,
                                    input logic [31:0] right, input logic [31:0] left);
      csr_write(CSR_HIGH_RES, {31'd0, hr});
      csr_write(CSR_COLOR_SPLIT, {24'd0, split});
      csr_write(CSR_BACKGROUND, {24'd0, background});
      csr_write(CSR_BLANK_LINE, {24'd0, blank});
      csr_write(CSR_RIGHT_COLORS, right);
      csr_write(CSR_LEFT_COLORS, left);
   endtask

   // Waits until every queued word is taken and every result has come, then lets
   // the pipeline run dry, since writes and line starts give no result.
   task automatic settle();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_chan.valid || expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Word driver: holds a word until taken, idles at random otherwise.
   always @(posedge clock) begin : feed_words
      scan_word_type   taken;
      pixel_group_type px;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            taken = {req_chan.mode, req_chan.line_number, req_chan.mem_address,
                     req_chan.mem_data};
            if (predict_scanout(taken, px)) begin
               expected_pixels.push_back(px);
            end
            void'(pending_words.pop_front());
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_words.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
               req_chan.valid <= 1'b1;
               req_chan.mode <= pending_words[0].mode;
               req_chan.line_number <= pending_words[0].line_number;
               req_chan.mem_address <= pending_words[0].mem_address;
               req_chan.mem_data <= pending_words[0].mem_data;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result ready: random stalls, plus one long hold-off when requested.
   always @(posedge clock) begin : pace_results
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= steady || $urandom_range(99) >= 20;
      end
   end

   // Result checker: each word against the oldest prediction.
   always @(posedge clock) begin : check_results
      pixel_group_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_pixels.size() == 0) begin
            failed = 1'b1;
            $display("%0t: unexpected result, expected none, actual %0h %0h %0h %0h %0b %0b",
                     $time, rsp_chan.pixel_a, rsp_chan.pixel_b, rsp_chan.pixel_c,
                     rsp_chan.pixel_d, rsp_chan.doubled, rsp_chan.line_end);
         end else begin
            want = expected_pixels.pop_front();
            compare_field("pixel_a", 32'(want.pixel_a), 32'(rsp_chan.pixel_a));
            compare_field("pixel_b", 32'(want.pixel_b), 32'(rsp_chan.pixel_b));
            compare_field("pixel_c", 32'(want.pixel_c), 32'(rsp_chan.pixel_c));
            compare_field("pixel_d", 32'(want.pixel_d), 32'(rsp_chan.pixel_d));
            compare_field("doubled", 32'(want.doubled), 32'(rsp_chan.doubled));
            compare_field("line_end", 32'(want.line_end), 32'(rsp_chan.line_end));
         end
      end
   end

   // Stimulus: a directed phase, then random phases under changing registers.
   initial begin : run_phases
      int phase_end;
      int line;
      int eff;
      int base;
      int slots;
      bit hr;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_WRITE;
      req_chan.line_number = '0;
      req_chan.mem_address = '0;
      req_chan.mem_data = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_HIGH_RES;
      csr_chan.data = '0;
      foreach (shadow_mem[i]) begin
         shadow_mem[i] = 8'h00;
      end
      cfg_high_res = 1'b0;
      cfg_split = '0;
      cfg_background = '0;
      cfg_blank = '0;
      cfg_right = '0;
      cfg_left = '0;
      fetch_addr = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed words in low-res: ignored slots and the unused mode, the address
      // and data extremes, line starts that wrap at the top of the frame.
      program_registers(1'b0, 8'd3, 8'h1B, 8'hFF, 32'h80FF_017F, 32'hFE00_C3A5);
      push_word(MODE_SLOT, 0, 0, 0);
      push_word(MODE_UNUSED, 511, 4095, 255);
      push_word(MODE_WRITE, 0, 0, 8'hE4);
      push_word(MODE_WRITE, 0, 4095, 8'hFF);
      push_word(MODE_WRITE, 0, 1, 8'h00);
      push_word(MODE_LINE, VERT_OFFSET, 0, 0);
      repeat (9) push_word(MODE_SLOT, 0, 0, 0);
      push_word(MODE_UNUSED, 0, 0, 0);
      push_word(MODE_LINE, 0, 0, 0);
      push_word(MODE_SLOT, 0, 0, 0);
      push_word(MODE_LINE, VERT_OFFSET - 1, 0, 0);
      push_word(MODE_SLOT, 0, 0, 0);
      push_word(MODE_LINE, LINES_PER_FRAME - 1, 0, 0);
      push_word(MODE_SLOT, 0, 0, 0);
      push_word(MODE_WRITE, 0, 4095, 8'h00);
      settle();

      for (int phase = 1; phase <= 7; phase++) begin
         case (phase)
            1: program_registers(1'b1, 8'h00, 8'h00, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
            2: program_registers(1'b0, 8'hFF, 8'hFF, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
            3: program_registers(1'b1, 8'($urandom_range(0, 90)), 8'($urandom), 8'hFF,
                                 $urandom, $urandom);
            4: program_registers(1'b0, 8'($urandom_range(0, 90)), 8'($urandom),
                                 8'($urandom_range(100, 255)), $urandom, $urandom);
            5: program_registers(1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
                                 $urandom, $urandom);
            6: program_registers(1'b0, 8'($urandom_range(0, 90)), 8'($urandom), 8'($urandom),
                                 $urandom, $urandom);
            default: program_registers(1'($urandom), 8'($urandom_range(0, 90)), 8'($urandom),
                                       8'($urandom_range(64, 255)), $urandom, $urandom);
         endcase
         // One phase runs without any idling; the next one holds results off for long.
         steady = (phase == 3);
         hold_request = (phase == 4);
         hr = cfg_high_res;
         phase_end = pending_words.size() + PHASE_WORDS;

         // Slots that carry on a line left open across the register change.
         repeat ($urandom_range(0, 20)) push_word(MODE_SLOT, $urandom, $urandom, $urandom);

         while (pending_words.size() < phase_end) begin
            line = $urandom_range(0, LINES_PER_FRAME - 1);
            eff = line - VERT_OFFSET;
            if (eff < 0) begin
               eff += LINES_PER_FRAME;
            end
            base = hr ? eff * WINDOW_BYTES : (eff / 2) * (WINDOW_BYTES / 2);

            // Fill part of the line's window, sometimes write anywhere.
            repeat ($urandom_range(2, 10)) begin
               push_word(MODE_WRITE, $urandom, base + $urandom_range(0, WINDOW_BYTES - 1),
                         $urandom);
            end
            if ($urandom_range(99) < 30) begin
               push_word(MODE_WRITE, $urandom, $urandom, $urandom);
            end
            push_word(MODE_LINE, line, $urandom, $urandom);

            // Mostly whole lines that run past their end; some cut short.
            if ($urandom_range(99) < 70) begin
               slots = (hr ? 80 : 40) + $urandom_range(0, 3);
            end else begin
               slots = $urandom_range(1, hr ? 79 : 39);
            end
            if (pending_words.size() + slots >= phase_end && $urandom_range(1) == 1) begin
               slots = $urandom_range(5, 30);
            end
            repeat (slots) begin
               if ($urandom_range(99) < 8) begin
                  push_word(MODE_WRITE, $urandom, base + $urandom_range(0, 2 * WINDOW_BYTES),
                            $urandom);
               end
               if ($urandom_range(99) < 3) begin
                  push_word(MODE_UNUSED, $urandom, $urandom, $urandom);
               end
               push_word(MODE_SLOT, $urandom, $urandom, $urandom);
            end
         end
         settle();
      end

      steady = 1'b0;
      repeat (10) @(posedge clock);
      if (!failed) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run, clearing pass included.
   initial begin : watchdog
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ scanline_pixel_scanout_top.f @@
rtl/sps_pkg.sv
rtl/sps_if.sv
rtl/sps_vram.sv
rtl/sps_seq.sv
rtl/sps_pixel.sv
rtl/scanline_pixel_scanout_top.sv
tb/sv/scanline_pixel_scanout_top_tb.sv
